// ===== design/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and codes for the sparse-table range minimum engine.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 10;

    // Operation codes carried on the func field.
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // One table entry: window minimum and the position that holds it.
    typedef struct packed {
        logic [IDX_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_append;
        logic merge;
        logic bump_count;
        logic clear_count;
        logic start_query;
        logic read_a;
        logic read_b;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic first_ok;
        logic next_ok;
        logic bad_query;
        logic out_free;
    } status_t;

endpackage

// ===== design/rmst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer for appends and queries of the range minimum engine.
// ----------------------------------------------------------------------------
module rmst_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rmst_pkg::FUNC_W-1:0]   s_func,
    input  rmst_pkg::status_t             status,
    output rmst_pkg::cmd_t                cmd
);
    import rmst_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MERGE = 5'b00010,
        ST_QA    = 5'b00100,
        ST_QB    = 5'b01000,
        ST_QOUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_func)
                        FUNC_APPEND: begin
                            if (!status.full) begin
                                cmd.start_append = 1'b1;
                                if (status.first_ok) begin
                                    state_next = ST_MERGE;
                                end else begin
                                    cmd.bump_count = 1'b1;
                                end
                            end
                        end
                        FUNC_QUERY: begin
                            cmd.start_query = 1'b1;
                            state_next = status.bad_query ? ST_QOUT : ST_QA;
                        end
                        FUNC_CLEAR: begin
                            cmd.clear_count = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                cmd.merge = 1'b1;
                if (!status.next_ok) begin
                    cmd.bump_count = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_QA: begin
                cmd.read_a = 1'b1;
                state_next = ST_QB;
            end
            ST_QB: begin
                cmd.read_b = 1'b1;
                state_next = ST_QOUT;
            end
            ST_QOUT: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A query always reaches the result state, and only from a read or from idle.
    a_qout_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QB) |=> (state_reg == ST_QOUT))
        else $error("query read sequence did not reach the result state");

    a_merge_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE && !status.next_ok) |=> (state_reg == ST_IDLE))
        else $error("append did not finish after its last level");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input taken while a previous item is still in work");

endmodule

// ===== design/rmst_dp.sv =====
// ----------------------------------------------------------------------------
// rmst_dp
// Table memory, element count, level merge logic and result register.
// ----------------------------------------------------------------------------
module rmst_dp #(
    parameter int CAPACITY = 1024,
    parameter int LEVELS   = 11
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmst_pkg::cmd_t                       cmd,
    output rmst_pkg::status_t                    status,
    input  logic signed [rmst_pkg::VALUE_W-1:0]  s_value,
    input  logic [rmst_pkg::IDX_W-1:0]           s_left,
    input  logic [rmst_pkg::IDX_W-1:0]           s_right,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rmst_pkg::VALUE_W-1:0]  m_min_value,
    output logic [rmst_pkg::IDX_W-1:0]           m_min_index,
    output logic                                 m_status
);
    import rmst_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LW  = $clog2(LEVELS + 1);
    localparam int LIW = $clog2(LEVELS);
    localparam int QW  = IDX_W + 1;
    localparam int FLW = $clog2(QW);

    function automatic entry_t pick_min(input entry_t a, input entry_t b);
        // The left operand wins a tie.
        return (a.val <= b.val) ? a : b;
    endfunction

    entry_t mem [LEVELS][CAPACITY];

    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    n_reg;
    logic [LW-1:0]    lvl_reg;
    entry_t           cur_reg;
    entry_t           rdata_reg;
    logic [IDX_W-1:0] left_reg;
    logic [IDX_W-1:0] right_reg;
    logic             bad_reg;
    logic [LW-1:0]    p_reg;
    logic [AW-1:0]    j_reg;
    logic             m_valid_reg;
    entry_t           res_reg;
    logic             res_bad_reg;

    // Append bookkeeping.
    logic [CW-1:0] np1;
    logic [LW-1:0] next_lvl;
    logic [AW-1:0] merge_wr_idx;
    logic [AW-1:0] next_rd_idx;
    entry_t        merged;

    // Query level selection.
    logic [QW-1:0]  qlen;
    logic [FLW-1:0] qlog;
    logic [LW-1:0]  p_calc;
    logic [AW-1:0]  j_calc;
    entry_t         qpick;

    // Memory port controls.
    logic          wr_en;
    logic [LW-1:0] wr_lvl;
    logic [AW-1:0] wr_idx;
    entry_t        wr_data;
    logic          rd_en;
    logic [LW-1:0] rd_lvl;
    logic [AW-1:0] rd_idx;

    assign np1          = n_reg + CW'(1);
    assign next_lvl     = lvl_reg + LW'(1);
    assign merge_wr_idx = AW'(np1 - (CW'(1) << lvl_reg));
    assign next_rd_idx  = AW'(np1 - (CW'(1) << next_lvl));
    assign merged       = pick_min(rdata_reg, cur_reg);

    assign qlen = QW'(right_reg) - QW'(left_reg) + QW'(1);

    always_comb begin
        qlog = '0;
        for (int b = 0; b < QW; b++) begin
            if (qlen[b]) begin
                qlog = FLW'(b);
            end
        end
    end

    assign p_calc = (32'(qlog) > LEVELS - 1) ? LW'(LEVELS - 1) : LW'(qlog);
    assign j_calc = AW'(QW'(right_reg) + QW'(1) - (QW'(1) << p_calc));
    assign qpick  = pick_min(cur_reg, rdata_reg);

    assign status.full      = (cnt_reg >= CW'(CAPACITY));
    assign status.first_ok  = (cnt_reg != '0);
    assign status.next_ok   = (32'(next_lvl) < LEVELS) && ((np1 >> next_lvl) != '0);
    assign status.bad_query = (s_left > s_right) || (32'(s_right) >= 32'(cnt_reg));
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_lvl  = '0;
        wr_idx  = AW'(cnt_reg);
        wr_data = merged;
        if (cmd.start_append) begin
            wr_en       = 1'b1;
            wr_data.val = s_value;
            wr_data.pos = IDX_W'(cnt_reg);
        end else if (cmd.merge) begin
            wr_en  = 1'b1;
            wr_lvl = lvl_reg;
            wr_idx = merge_wr_idx;
        end
    end

    always_comb begin
        rd_en  = 1'b0;
        rd_lvl = '0;
        rd_idx = AW'(cnt_reg - CW'(1));
        if (cmd.start_append) begin
            rd_en = status.first_ok;
        end else if (cmd.merge) begin
            rd_en  = status.next_ok;
            rd_lvl = lvl_reg;
            rd_idx = next_rd_idx;
        end else if (cmd.read_a) begin
            rd_en  = 1'b1;
            rd_lvl = p_calc;
            rd_idx = AW'(left_reg);
        end else if (cmd.read_b) begin
            rd_en  = 1'b1;
            rd_lvl = p_reg;
            rd_idx = j_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_lvl[LIW-1:0]][wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_lvl[LIW-1:0]][rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_append) begin
            n_reg       <= cnt_reg;
            lvl_reg     <= LW'(1);
            cur_reg.val <= s_value;
            cur_reg.pos <= IDX_W'(cnt_reg);
        end else if (cmd.merge) begin
            lvl_reg <= next_lvl;
            cur_reg <= merged;
        end else if (cmd.read_b) begin
            cur_reg <= rdata_reg;
        end
        if (cmd.start_query) begin
            left_reg  <= s_left;
            right_reg <= s_right;
            bad_reg   <= status.bad_query;
        end
        if (cmd.read_a) begin
            p_reg <= p_calc;
            j_reg <= j_calc;
        end
        if (cmd.load_result) begin
            res_reg     <= qpick;
            res_bad_reg <= bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_count) begin
                cnt_reg <= '0;
            end else if (cmd.bump_count) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_min_value = res_bad_reg ? '0 : res_reg.val;
    assign m_min_index = res_bad_reg ? '0 : res_reg.pos;
    assign m_status    = res_bad_reg ? STATUS_BAD : STATUS_OK;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("element count ran past capacity");

    a_merge_level: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> (lvl_reg != '0) && (32'(lvl_reg) < LEVELS))
        else $error("merge issued for a level outside the table");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> status.out_free)
        else $error("result register overwritten before it was taken");

    a_bump: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bump_count && !cmd.clear_count |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("element count did not advance after an append");

endmodule

// ===== design/range_min_sparse_table_top.sv =====
// Append: the first element is written to level zero in the accept cycle; any later one is
// then merged into each table level that it completes, one level at a time. Query: a good
// range passes through two table reads before its result is registered; a bad range skips
// them. The next item is taken once the result is loaded, later while an older result waits.
// Clear and unused codes finish in the accept cycle. One item is in work at a time. Reset
// clears the count and output valid; the table is not, as no valid query reads past the fill.
// ----------------------------------------------------------------------------
// range_min_sparse_table_top
// Sparse-table range minimum engine built incrementally by appends.
// ----------------------------------------------------------------------------
module range_min_sparse_table_top #(
    parameter int CAPACITY = 1024,
    parameter int LEVELS   = 11
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rmst_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [rmst_pkg::VALUE_W-1:0]  s_value,
    input  logic [rmst_pkg::IDX_W-1:0]           s_left,
    input  logic [rmst_pkg::IDX_W-1:0]           s_right,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [rmst_pkg::VALUE_W-1:0]  m_min_value,
    output logic [rmst_pkg::IDX_W-1:0]           m_min_index,
    output logic                                 m_status
);
    import rmst_pkg::*;

    // The controller only steps through the work of one item; all storage,
    // the element count and the result register live in the datapath.
    cmd_t    cmd;
    status_t status;

    // The controller takes an item only when idle. An append writes level zero
    // in the accept cycle and, unless the table was empty, then merges one level per
    // cycle; each merge reads the left half-window while the right half is carried in a register.
    rmst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // A query reads the window that starts at the left bound and the window
    // that ends at the right bound; the left one wins a tie. The result item
    // waits in the output register so the next item can be taken meanwhile.
    rmst_dp #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_value     (s_value),
        .s_left      (s_left),
        .s_right     (s_right),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_value (m_min_value),
        .m_min_index (m_min_index),
        .m_status    (m_status)
    );

endmodule
